// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; they compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define BRWI_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BRWI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

// The expression must never be true.
`define BRWI_ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("assertion failed");

`else

`define BRWI_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define BRWI_ASSERT_NEXT(label, clk, rstn, ante, cons)
`define BRWI_ASSERT_NEVER(label, clk, rstn, expr)

`endif

`endif

// ===== rtl/brwi_pkg.sv =====
// ----------------------------------------------------------------------------
// brwi_pkg
// Shared constants and types of the beat rate window interpolator.
// ----------------------------------------------------------------------------
package brwi_pkg;

    // Defaults of the top level parameters.
    localparam int DEF_RESAMPLE_RATE = 4;
    localparam int DEF_MAX_BEATS     = 256;
    localparam int DEF_MAX_OUT       = 64;

    // Field widths.
    localparam int BEAT_W  = 24;
    localparam int VALUE_W = 24;
    localparam int IDX_W   = 6;
    localparam int WS_W    = 5;
    localparam int RATE_W  = 13;
    localparam int CFG_IDX_W = 8;

    // Arithmetic widths.
    localparam int POS_W = 32;
    localparam int CNT_W = 32;
    localparam int SUM_W = 40;
    localparam int DIV_W = 64;

    localparam logic [CNT_W-1:0]   ONE_Q16   = 32'h0001_0000;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 24'hFF_FFFF;

    // Reset values of the configuration registers.
    localparam logic [WS_W-1:0]   WS_RESET   = 5'd16;
    localparam logic [RATE_W-1:0] RATE_RESET = 13'd250;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_SECONDS = 8'd0,
        CFG_INPUT_RATE     = 8'd1
    } cfg_idx_t;

endpackage

// ===== rtl/brwi_ram.sv =====
// ----------------------------------------------------------------------------
// brwi_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module brwi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/brwi_div.sv =====
// ----------------------------------------------------------------------------
// brwi_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module brwi_div #(
    parameter int W = brwi_pkg::DIV_W
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic         done,
    output logic [W-1:0] quo
);

    localparam int SW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  den_reg, den_next;
    logic [W:0]    shifted;
    logic [W:0]    trial;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = SW'(W);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end else if (busy_reg) begin
            // The remainder stays below the divisor, so W bits hold it.
            if (!trial[W]) begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - SW'(1);
            if (cnt_reg == SW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/beat_rate_window_interpolator.sv =====
// ----------------------------------------------------------------------------
// beat_rate_window_interpolator
// Berger interpolation of beat intervals over one window of resampled output.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  s_        in         tdata: beat_time; tlast: last_beat
//  m_        out        tdata: interval_value, sample_index; tlast: last_sample;
//                       tuser: no_valid
//  cfg_      in         cfg_index selects the register, cfg_data is the value
//
// A beat without tlast is stored as it is accepted, unless the store is full. A beat with
// tlast starts the window computation; s_tready stays low until the last result beat leaves.
// Each sample reads the beat store and runs the shared divider once per fractional
// interval term; a result with a nonzero count runs it once, unless no sample is
// valid. The mean adds one more division. aresetn is synchronous and active low.
// A stalled m_tready holds the result and the sequencer in place.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module beat_rate_window_interpolator #(
    parameter int RESAMPLE_RATE = brwi_pkg::DEF_RESAMPLE_RATE,
    parameter int MAX_BEATS     = brwi_pkg::DEF_MAX_BEATS,
    parameter int MAX_OUT       = brwi_pkg::DEF_MAX_OUT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input beats.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] beat_time
    input  logic        s_tlast,   // last_beat
    // Result beats.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [23:0] interval_value, [29:24] sample_index
    output logic        m_tlast,   // last_sample
    output logic [0:0]  m_tuser,   // [0] no_valid
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int AW  = $clog2(MAX_BEATS);
    localparam int CW  = $clog2(MAX_BEATS + 1);
    localparam int OAW = $clog2(MAX_OUT);
    localparam int NW  = $clog2(MAX_OUT + 1);
    localparam int PW  = brwi_pkg::POS_W;
    localparam int BW  = brwi_pkg::BEAT_W;
    localparam int DW  = brwi_pkg::DIV_W;
    localparam int KW  = brwi_pkg::CNT_W;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SETUP,
        S_SAMPLE,
        S_BASE_RD,
        S_BASE_CHK,
        S_CHECK,
        S_RD_A,
        S_RD_B,
        S_GET_B,
        S_TERM,
        S_DIV_T,
        S_ADV,
        S_NEXT,
        S_MEAN,
        S_DIV_M,
        S_OUT_SETUP,
        S_OUT_RD,
        S_OUT_CNT,
        S_OUT_MUL,
        S_OUT_DIVS,
        S_OUT_DIV,
        S_OUT
    } state_t;

    state_t                          state_reg;
    logic [CW-1:0]                   bc_reg;
    logic [BW-1:0]                   prev_beat_reg;
    logic [BW-1:0]                   first_beat_reg;
    logic [brwi_pkg::WS_W-1:0]       ws_reg;
    logic [brwi_pkg::RATE_W-1:0]     rate_reg;
    logic [brwi_pkg::RATE_W-1:0]     fs_reg;
    logic [NW-1:0]                   nout_reg;
    logic [NW-1:0]                   n_reg;
    logic [CW-1:0]                   base_reg;
    logic [CW-1:0]                   k_reg;
    logic signed [PW-1:0]            lo_reg, mid_reg, hi_reg;
    logic signed [PW-1:0]            a_reg, b_reg;
    logic [KW-1:0]                   c_reg;
    logic [brwi_pkg::SUM_W-1:0]      sum_reg;
    logic [NW-1:0]                   vcnt_reg;
    logic [KW-1:0]                   mean_reg;
    logic                            none_reg;
    logic [19:0]                     fsn_reg;
    logic [KW-1:0]                   cnt_reg;
    logic [DW-1:0]                   den_reg;
    logic [brwi_pkg::VALUE_W-1:0]    val_reg;

    // Handshakes.
    logic s_accept, m_accept, cfg_accept;
    assign s_tready   = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign s_accept   = s_tvalid && s_tready;
    assign m_accept   = m_tvalid && m_tready;
    assign cfg_accept = cfg_valid && cfg_ready;

    // A beat that runs backward is stored as the previous beat.
    logic [BW-1:0] beat_fix;
    logic          store_full;
    assign beat_fix   = (bc_reg != '0 && s_tdata < prev_beat_reg) ? prev_beat_reg : s_tdata;
    assign store_full = (bc_reg >= CW'(MAX_BEATS));

    function automatic logic signed [PW-1:0] pos_of(input logic [BW-1:0] beat);
        pos_of = $signed(PW'(beat) * PW'(RESAMPLE_RATE));
    endfunction

    // Beat store.
    logic          bw_en;
    logic [AW-1:0] b_raddr;
    logic [BW-1:0] b_rdata;
    logic [CW-1:0] base_inc, k_dec;

    assign bw_en    = s_accept && !store_full;
    assign base_inc = base_reg + CW'(1);
    assign k_dec    = k_reg - CW'(1);

    always_comb begin
        unique case (state_reg)
            S_BASE_RD: b_raddr = base_inc[AW-1:0];
            S_RD_A:    b_raddr = k_dec[AW-1:0];
            S_RD_B:    b_raddr = k_reg[AW-1:0];
            default:   b_raddr = '0;
        endcase
    end

    brwi_ram #(.WIDTH(BW), .DEPTH(MAX_BEATS)) u_beat_ram (
        .aclk  (aclk),
        .we    (bw_en),
        .waddr (bc_reg[AW-1:0]),
        .wdata (beat_fix),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    logic signed [PW-1:0] rd_pos;
    assign rd_pos = pos_of(b_rdata);

    // Fraction of one beat interval that lies inside the window.
    logic signed [PW-1:0] t_num, t_den;
    logic                 t_inside;
    logic                 t_zero, t_full;

    always_comb begin
        t_den    = b_reg - a_reg;
        t_inside = (a_reg >= lo_reg) && (b_reg < hi_reg);
        if (a_reg < lo_reg && b_reg < hi_reg) begin
            t_num = b_reg - lo_reg;
        end else if (a_reg > lo_reg) begin
            t_num = hi_reg - a_reg;
        end else begin
            t_num = $signed(PW'(fs_reg) << 1);
        end
        t_zero = (t_den <= 0) || (t_num <= 0);
        t_full = (t_num >= t_den);
    end

    // Count store: saturated Q16.16 count with its valid flag on top.
    logic            cw_en;
    logic            cw_valid;
    logic [KW:0]     c_rdata;
    logic            b_below_hi;

    assign b_below_hi = (b_reg < hi_reg);

    always_comb begin
        cw_en    = 1'b0;
        cw_valid = 1'b0;
        unique case (state_reg)
            S_SAMPLE: cw_en = (n_reg + NW'(1) >= nout_reg);
            S_CHECK:  cw_en = !((mid_reg > pos_of(first_beat_reg)) && (base_inc < bc_reg));
            S_RD_A:   cw_en = (k_reg >= bc_reg);
            S_ADV: begin
                cw_en    = !b_below_hi;
                cw_valid = 1'b1;
            end
            default:  cw_en = 1'b0;
        endcase
    end

    brwi_ram #(.WIDTH(KW + 1), .DEPTH(MAX_OUT)) u_count_ram (
        .aclk  (aclk),
        .we    (cw_en),
        .waddr (n_reg[OAW-1:0]),
        .wdata (cw_valid ? {1'b1, c_reg} : '0),
        .raddr (n_reg[OAW-1:0]),
        .rdata (c_rdata)
    );

    // The shared divider serves interval fractions, the mean and the results.
    logic          div_start, div_done;
    logic [DW-1:0] div_num, div_den, div_quo;

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (state_reg)
            S_TERM: begin
                div_start = !t_inside && !t_zero && !t_full;
                div_num   = DW'(t_num) << 16;
                div_den   = DW'(t_den);
            end
            S_MEAN: begin
                div_start = (vcnt_reg != '0);
                div_num   = DW'(sum_reg);
                div_den   = DW'(vcnt_reg);
            end
            S_OUT_DIVS: begin
                div_start = 1'b1;
                div_num   = DW'(prev_beat_reg) << 33;
                div_den   = den_reg;
            end
            default: div_start = 1'b0;
        endcase
    end

    brwi_div #(.W(DW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    function automatic logic [KW-1:0] sat_add(input logic [KW-1:0] x, input logic [KW-1:0] y);
        logic [KW:0] s;
        s = {1'b0, x} + {1'b0, y};
        sat_add = s[KW] ? '1 : s[KW-1:0];
    endfunction

    // Effective settings: a zero register acts as one, the window is capped.
    logic [brwi_pkg::RATE_W-1:0] fs_eff;
    logic [brwi_pkg::WS_W-1:0]   ws_eff;
    logic [15:0]                 nprod;
    assign fs_eff = (rate_reg == '0) ? brwi_pkg::RATE_W'(1) : rate_reg;
    assign ws_eff = (ws_reg == '0) ? brwi_pkg::WS_W'(1) : ws_reg;
    assign nprod  = 16'(ws_eff) * 16'(RESAMPLE_RATE);

    logic signed [PW-1:0] fs_pos;
    assign fs_pos = $signed(PW'(fs_reg));

    logic [KW-1:0] out_cnt;
    assign out_cnt = c_rdata[KW] ? c_rdata[KW-1:0] : mean_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            bc_reg    <= '0;
            ws_reg    <= brwi_pkg::WS_RESET;
            rate_reg  <= brwi_pkg::RATE_RESET;
        end else begin
            if (cfg_accept) begin
                if (cfg_index == brwi_pkg::CFG_WINDOW_SECONDS) begin
                    ws_reg <= cfg_data[brwi_pkg::WS_W-1:0];
                end else if (cfg_index == brwi_pkg::CFG_INPUT_RATE) begin
                    rate_reg <= cfg_data;
                end
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        if (!store_full) begin
                            bc_reg        <= bc_reg + CW'(1);
                            prev_beat_reg <= beat_fix;
                            if (bc_reg == '0) begin
                                first_beat_reg <= beat_fix;
                            end
                        end
                        if (s_tlast) begin
                            state_reg <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    fs_reg    <= fs_eff;
                    nout_reg  <= (nprod > 16'(MAX_OUT)) ? NW'(MAX_OUT) : NW'(nprod);
                    n_reg     <= '0;
                    lo_reg    <= -$signed(PW'(fs_eff));
                    mid_reg   <= '0;
                    hi_reg    <= $signed(PW'(fs_eff));
                    base_reg  <= '0;
                    sum_reg   <= '0;
                    vcnt_reg  <= '0;
                    state_reg <= S_SAMPLE;
                end
                S_SAMPLE: begin
                    // The final sample of the window is never valid.
                    state_reg <= (n_reg + NW'(1) >= nout_reg) ? S_MEAN : S_BASE_RD;
                end
                S_BASE_RD: begin
                    state_reg <= (base_inc < bc_reg) ? S_BASE_CHK : S_CHECK;
                end
                S_BASE_CHK: begin
                    if (rd_pos < lo_reg) begin
                        base_reg  <= base_inc;
                        state_reg <= S_BASE_RD;
                    end else begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if ((mid_reg > pos_of(first_beat_reg)) && (base_inc < bc_reg)) begin
                        k_reg     <= base_inc;
                        c_reg     <= '0;
                        state_reg <= S_RD_A;
                    end else begin
                        state_reg <= S_NEXT;
                    end
                end
                S_RD_A: begin
                    // Running past the last stored beat leaves the sample invalid.
                    state_reg <= (k_reg >= bc_reg) ? S_NEXT : S_RD_B;
                end
                S_RD_B: begin
                    a_reg     <= rd_pos;
                    state_reg <= S_GET_B;
                end
                S_GET_B: begin
                    b_reg     <= rd_pos;
                    state_reg <= S_TERM;
                end
                S_TERM: begin
                    if (t_inside || (!t_zero && t_full)) begin
                        c_reg     <= sat_add(c_reg, brwi_pkg::ONE_Q16);
                        state_reg <= S_ADV;
                    end else if (t_zero) begin
                        state_reg <= S_ADV;
                    end else begin
                        state_reg <= S_DIV_T;
                    end
                end
                S_DIV_T: begin
                    if (div_done) begin
                        c_reg     <= sat_add(c_reg, div_quo[KW-1:0]);
                        state_reg <= S_ADV;
                    end
                end
                S_ADV: begin
                    if (b_below_hi) begin
                        k_reg     <= k_reg + CW'(1);
                        state_reg <= S_RD_A;
                    end else begin
                        if (c_reg != '0) begin
                            sum_reg  <= sum_reg + brwi_pkg::SUM_W'(c_reg);
                            vcnt_reg <= vcnt_reg + NW'(1);
                        end
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    n_reg     <= n_reg + NW'(1);
                    lo_reg    <= lo_reg + fs_pos;
                    mid_reg   <= mid_reg + fs_pos;
                    hi_reg    <= hi_reg + fs_pos;
                    state_reg <= S_SAMPLE;
                end
                S_MEAN: begin
                    none_reg <= (vcnt_reg == '0);
                    mean_reg <= '0;
                    state_reg <= (vcnt_reg == '0) ? S_OUT_SETUP : S_DIV_M;
                end
                S_DIV_M: begin
                    if (div_done) begin
                        mean_reg  <= div_quo[KW-1:0];
                        state_reg <= S_OUT_SETUP;
                    end
                end
                S_OUT_SETUP: begin
                    fsn_reg   <= 20'(fs_reg) * 20'(nout_reg);
                    n_reg     <= '0;
                    state_reg <= S_OUT_RD;
                end
                S_OUT_RD: begin
                    state_reg <= S_OUT_CNT;
                end
                S_OUT_CNT: begin
                    cnt_reg <= out_cnt;
                    if (none_reg) begin
                        val_reg   <= '0;
                        state_reg <= S_OUT;
                    end else if (out_cnt == '0) begin
                        val_reg   <= brwi_pkg::VALUE_MAX;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_OUT_MUL;
                    end
                end
                S_OUT_MUL: begin
                    den_reg   <= DW'(fsn_reg) * DW'(cnt_reg);
                    state_reg <= S_OUT_DIVS;
                end
                S_OUT_DIVS: begin
                    state_reg <= S_OUT_DIV;
                end
                S_OUT_DIV: begin
                    if (div_done) begin
                        val_reg <= (div_quo > DW'(brwi_pkg::VALUE_MAX)) ?
                                   brwi_pkg::VALUE_MAX : div_quo[brwi_pkg::VALUE_W-1:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_accept) begin
                        if (n_reg + NW'(1) == nout_reg) begin
                            bc_reg    <= '0;
                            state_reg <= S_IDLE;
                        end else begin
                            n_reg     <= n_reg + NW'(1);
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {2'b00, brwi_pkg::IDX_W'(n_reg), val_reg};
    assign m_tlast  = (n_reg + NW'(1) == nout_reg);
    assign m_tuser  = none_reg;

    `BRWI_ASSERT_NEVER(a_sides_exclusive, aclk, aresetn, s_tready && m_tvalid)
    `BRWI_ASSERT_IMPL(a_none_gives_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[23:0] == '0)
    `BRWI_ASSERT_IMPL(a_count_in_range, aclk, aresetn, 1'b1, bc_reg <= CW'(MAX_BEATS))
    `BRWI_ASSERT_NEXT(a_store_emptied, aclk, aresetn, m_accept && m_tlast, bc_reg == '0 && s_tready)

endmodule
